/* src/hfos_pkg.sv */
package hfos_pkg;

   // number format
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int ACC_BITS  = 44;
   localparam int M_BITS    = 42;
   localparam int QB_BITS   = WORD_BITS - 1;
   localparam int PRE_SHIFT = WORD_BITS - 1 - FRAC_BITS;

   // configuration register indexes
   localparam logic [1:0] REG_DEGREE     = 2'd0;
   localparam logic [1:0] REG_RELAX_REAL = 2'd1;
   localparam logic [1:0] REG_RELAX_IMAG = 2'd2;
   localparam logic [1:0] REG_EPSILON    = 2'd3;

   localparam logic req_type_LOAD = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_POW, ST_PA, ST_PA2, ST_F2, ST_F1, ST_NUM, ST_DIVM, ST_DIVP,
      ST_DIVRE, ST_DIVIM, ST_N2, ST_RL, ST_NRM, ST_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_Z_RE, OP_Z_IM, OP_P1_RE, OP_P1_IM, OP_P0_RE, OP_P0_IM, OP_F2_RE, OP_F2_IM,
      OP_FX_RE, OP_FX_IM, OP_CA_RE, OP_CA_IM, OP_CB_RE, OP_CB_IM, OP_RL_RE, OP_RL_IM,
      OP_S_RE, OP_S_IM, OP_NW_RE, OP_NW_IM, OP_K1, OP_K2
   } opnd_type;

   typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} accop_type;

   // one multiplier issue and what to do with its product
   typedef struct packed {
      logic      valid;
      opnd_type  opa;
      opnd_type  opb;
      logic      raw;
      logic      acc_sel;
      accop_type op;
   } issue_type;

   // number of products each state issues
   function automatic logic [2:0] num_prod(state_type s);
      unique case (s)
         ST_POW, ST_PA, ST_PA2, ST_NUM, ST_DIVM, ST_RL, ST_NRM: return 3'd4;
         ST_F2, ST_F1, ST_DIVP:                                 return 3'd2;
         default:                                               return 3'd0;
      endcase
   endfunction

   function automatic logic signed [ACC_BITS-1:0] ext(logic signed [WORD_BITS-1:0] x);
      return {{(ACC_BITS-WORD_BITS){x[WORD_BITS-1]}}, x};
   endfunction

   // saturate a wide value to the word
   function automatic logic signed [WORD_BITS-1:0] sat_word(logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] hi;
      logic signed [ACC_BITS-1:0] lo;
      hi = ext({1'b0, {(WORD_BITS-1){1'b1}}});
      lo = ext({1'b1, {(WORD_BITS-1){1'b0}}});
      if (v > hi) return hi[WORD_BITS-1:0];
      if (v < lo) return lo[WORD_BITS-1:0];
      return v[WORD_BITS-1:0];
   endfunction

endpackage

/* src/halley_fractal_orbit_step.sv */
// Relaxed Halley step of z^(a+1) - z on a stored point, one shared 32x32 multiplier.
// Load request: accepted in idle, result registered in the next cycle.
// Step request: runs the multiplier issue sequence (four products per complex multiply)
// and the radix-2 restoring divider, run four times (a divide whose quotient saturates
// or whose divisor is zero skips the quotient-bit iterations).
// One request at a time; ready again once the result is registered and the output is free.
// Synchronous active-high reset clears control state and stored point, and sets configuration defaults.
module halley_fractal_orbit_step #(
   parameter int MAX_DEGREE = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic signed [31:0]          req_start_real,
   input  logic signed [31:0]          req_start_imag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_new_real,
   output logic signed [31:0]          rsp_new_imag,
   output logic                        rsp_converged,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import hfos_pkg::*;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   // configuration
   logic [4:0]  degree_ff;
   word_type    relax_re_ff, relax_im_ff;
   logic [30:0] epsilon_ff;

   // control
   state_type   state_ff, state_in;
   logic [2:0]  sub_ff;
   logic [4:0]  pcnt_ff;
   logic [4:0]  dcnt_ff;
   logic        pass_ff;
   logic        conv_ff;
   logic        rsp_valid_ff;

   // datapath
   word_type    old_re_ff, old_im_ff;
   word_type    p1_re_ff, p1_im_ff, p0_re_ff, p0_im_ff;
   word_type    fx_re_ff, fx_im_ff, f1_re_ff, f1_im_ff, f2_re_ff, f2_im_ff;
   word_type    ca_re_ff, ca_im_ff, cb_re_ff, cb_im_ff;
   word_type    s_re_ff, s_im_ff, nw_re_ff, nw_im_ff;
   logic [5:0]  k1_ff;
   logic [9:0]  k2_ff;
   logic signed [2*WORD_BITS-1:0] prod_ff;
   issue_type   ctl_ff, issue;
   acc_type     acc0_ff, acc1_ff, acc0_in, acc1_in;
   logic [M_BITS-1:0] m_ff;
   acc_type     pre_ff, pim_ff;
   logic [M_BITS:0]   rem_ff;
   logic [QB_BITS-1:0] nb_ff, qb_ff;
   word_type    rsp_re_ff, rsp_im_ff;
   logic        rsp_conv_ff;

   logic        req_fire, cfg_write, wb, div_done, out_free, fin_go;
   word_type    div_res;
   logic [4:0]  a_clamp;

   assign req_fire  = req_valid && req_ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wb        = (sub_ff == num_prod(state_ff));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_go    = (state_ff == ST_FIN) && out_free;

   // degree clamped to the supported range
   always_comb begin
      if (degree_ff < 5'd2) a_clamp = 5'd2;
      else if ({2'b00, degree_ff} > 7'(MAX_DEGREE)) a_clamp = 5'(MAX_DEGREE);
      else a_clamp = degree_ff;
   end

   // operand select for the shared multiplier
   function automatic word_type opnd(opnd_type o, word_type zr, word_type zi,
         word_type p1r, word_type p1i, word_type p0r, word_type p0i,
         word_type f2r, word_type f2i, word_type fxr, word_type fxi,
         word_type car, word_type cai, word_type cbr, word_type cbi,
         word_type rlr, word_type rli, word_type sr, word_type si,
         word_type nwr, word_type nwi, logic [5:0] k1, logic [9:0] k2);
      unique case (o)
         OP_Z_RE:  return zr;
         OP_Z_IM:  return zi;
         OP_P1_RE: return p1r;
         OP_P1_IM: return p1i;
         OP_P0_RE: return p0r;
         OP_P0_IM: return p0i;
         OP_F2_RE: return f2r;
         OP_F2_IM: return f2i;
         OP_FX_RE: return fxr;
         OP_FX_IM: return fxi;
         OP_CA_RE: return car;
         OP_CA_IM: return cai;
         OP_CB_RE: return cbr;
         OP_CB_IM: return cbi;
         OP_RL_RE: return rlr;
         OP_RL_IM: return rli;
         OP_S_RE:  return sr;
         OP_S_IM:  return si;
         OP_NW_RE: return nwr;
         OP_NW_IM: return nwi;
         OP_K1:    return {{(WORD_BITS-6){1'b0}}, k1};
         OP_K2:    return {{(WORD_BITS-10){1'b0}}, k2};
         default:  return '0;
      endcase
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && req_type != req_type_LOAD)
                      state_in = (a_clamp == 5'd2) ? ST_PA : ST_POW;
         ST_POW:   if (wb && pcnt_ff == 5'd1) state_in = ST_PA;
         ST_PA:    if (wb) state_in = ST_PA2;
         ST_PA2:   if (wb) state_in = ST_F2;
         ST_F2:    if (wb) state_in = ST_F1;
         ST_F1:    if (wb) state_in = ST_NUM;
         ST_NUM:   if (wb) state_in = ST_DIVM;
         ST_DIVM:  if (wb) state_in = ST_DIVP;
         ST_DIVP:  if (wb) state_in = ST_DIVRE;
         ST_DIVRE: if (div_done) state_in = ST_DIVIM;
         ST_DIVIM: if (div_done) state_in = pass_ff ? ST_RL : ST_N2;
         ST_N2:    state_in = ST_DIVM;
         ST_RL:    if (wb) state_in = ST_NRM;
         ST_NRM:   if (wb) state_in = ST_FIN;
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs: multiplier issue sequence and handshake
   always_comb begin
      opnd_type ar, ai, br, bi;
      ar = OP_Z_RE; ai = OP_Z_IM; br = OP_P1_RE; bi = OP_P1_IM;
      issue = '{valid: 1'b0, opa: OP_Z_RE, opb: OP_Z_RE, raw: 1'b0, acc_sel: 1'b0,
                op: ACC_LOAD};
      req_ready = (state_ff == ST_IDLE) && out_free;
      unique case (state_ff)
         ST_PA2: begin br = OP_P0_RE; bi = OP_P0_IM; end
         ST_NUM: begin ar = OP_F2_RE; ai = OP_F2_IM; br = OP_FX_RE; bi = OP_FX_IM; end
         ST_RL:  begin ar = OP_RL_RE; ai = OP_RL_IM; br = OP_S_RE; bi = OP_S_IM; end
         default: ;
      endcase
      if (!wb) begin
         issue.valid = 1'b1;
         unique case (state_ff)
            ST_POW, ST_PA, ST_PA2, ST_NUM, ST_RL: begin
               // complex product, each partial floored
               unique case (sub_ff[1:0])
                  2'd0: begin issue.opa = ar; issue.opb = br; end
                  2'd1: begin issue.opa = ai; issue.opb = bi; issue.op = ACC_SUB; end
                  2'd2: begin issue.opa = ar; issue.opb = bi; issue.acc_sel = 1'b1; end
                  default: begin
                     issue.opa = ai; issue.opb = br; issue.acc_sel = 1'b1;
                     issue.op = ACC_ADD;
                  end
               endcase
            end
            ST_F2, ST_F1: begin
               issue.raw = 1'b1;
               issue.opa = (state_ff == ST_F2) ? OP_K2 : OP_K1;
               issue.opb = (state_ff == ST_F2) ?
                           (sub_ff[0] ? OP_P1_IM : OP_P1_RE) :
                           (sub_ff[0] ? OP_P0_IM : OP_P0_RE);
               issue.acc_sel = sub_ff[0];
            end
            ST_DIVM: begin
               // divisor norm, then real part of a * conj(b)
               unique case (sub_ff[1:0])
                  2'd0: begin issue.opa = OP_CB_RE; issue.opb = OP_CB_RE; end
                  2'd1: begin
                     issue.opa = OP_CB_IM; issue.opb = OP_CB_IM; issue.op = ACC_ADD;
                  end
                  2'd2: begin issue.opa = OP_CA_RE; issue.opb = OP_CB_RE; issue.acc_sel = 1'b1; end
                  default: begin
                     issue.opa = OP_CA_IM; issue.opb = OP_CB_IM; issue.acc_sel = 1'b1;
                     issue.op = ACC_ADD;
                  end
               endcase
            end
            ST_DIVP: begin
               issue.opa = sub_ff[0] ? OP_CA_RE : OP_CA_IM;
               issue.opb = sub_ff[0] ? OP_CB_IM : OP_CB_RE;
               issue.op  = sub_ff[0] ? ACC_SUB : ACC_LOAD;
            end
            ST_NRM: begin
               // |new|^2 - |old|^2
               unique case (sub_ff[1:0])
                  2'd0: begin issue.opa = OP_NW_RE; issue.opb = OP_NW_RE; end
                  2'd1: begin issue.opa = OP_NW_IM; issue.opb = OP_NW_IM; issue.op = ACC_ADD; end
                  2'd2: begin issue.opa = OP_Z_RE; issue.opb = OP_Z_RE; issue.op = ACC_SUB; end
                  default: begin issue.opa = OP_Z_IM; issue.opb = OP_Z_IM; issue.op = ACC_SUB; end
               endcase
            end
            default: issue.valid = 1'b0;
         endcase
      end
   end

   // accumulate the product issued last cycle
   always_comb begin
      acc_type term, cur, res;
      term = ctl_ff.raw ? prod_ff[ACC_BITS-1:0] :
             {{(ACC_BITS-(2*WORD_BITS-FRAC_BITS)){prod_ff[2*WORD_BITS-1]}},
              prod_ff[2*WORD_BITS-1:FRAC_BITS]};
      cur = ctl_ff.acc_sel ? acc1_ff : acc0_ff;
      unique case (ctl_ff.op)
         ACC_ADD: res = cur + term;
         ACC_SUB: res = cur - term;
         default: res = term;
      endcase
      acc0_in = (ctl_ff.valid && !ctl_ff.acc_sel) ? res : acc0_ff;
      acc1_in = (ctl_ff.valid &&  ctl_ff.acc_sel) ? res : acc1_ff;
   end

   // divider: numerator of the active component, special cases, last quotient bit
   acc_type            div_n;
   word_type           div_a;
   logic [M_BITS-1:0]  div_u;
   logic               div_neg, div_spec;
   logic [M_BITS:0]    div_trial;
   logic               div_bit;
   logic [QB_BITS-1:0] div_q;
   always_comb begin
      div_n     = (state_ff == ST_DIVIM) ? pim_ff : pre_ff;
      div_a     = (state_ff == ST_DIVIM) ? ca_im_ff : ca_re_ff;
      div_neg   = div_n[ACC_BITS-1];
      div_u     = div_neg ? M_BITS'(-div_n) : div_n[M_BITS-1:0];
      div_spec  = (m_ff == '0) ||
                  ({{PRE_SHIFT{1'b0}}, div_u} >= {m_ff, {PRE_SHIFT{1'b0}}});
      div_trial = {rem_ff[M_BITS-1:0], nb_ff[QB_BITS-1]} - {1'b0, m_ff};
      div_bit   = !div_trial[M_BITS];
      div_q     = {qb_ff[QB_BITS-2:0], div_bit};
      div_done  = ((dcnt_ff == 5'd0) && div_spec) || (dcnt_ff == 5'(QB_BITS));
      if (dcnt_ff == 5'd0) begin
         // zero divisor: saturate by the sign of the dividend component itself
         if (m_ff == '0) begin
            if (div_a == '0) div_res = '0;
            else div_res = div_a[WORD_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} :
                                                {1'b0, {(WORD_BITS-1){1'b1}}};
         end else begin
            div_res = div_neg ? {1'b1, {(WORD_BITS-1){1'b0}}} :
                                {1'b0, {(WORD_BITS-1){1'b1}}};
         end
      end else begin
         div_res = div_neg ? -word_type'({1'b0, div_q}) : word_type'({1'b0, div_q});
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= '0;
         dcnt_ff      <= '0;
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         degree_ff    <= 5'd2;
         relax_re_ff  <= 32'sh0100_0000;
         relax_im_ff  <= '0;
         epsilon_ff   <= 31'd1678;
         old_re_ff    <= '0;
         old_im_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ctl_ff   <= issue;
         sub_ff   <= (num_prod(state_ff) == 3'd0 || wb) ? 3'd0 : sub_ff + 3'd1;
         if (state_ff == ST_DIVRE || state_ff == ST_DIVIM)
            dcnt_ff <= div_done ? 5'd0 : dcnt_ff + 5'd1;
         else
            dcnt_ff <= '0;
         // configuration writes
         if (cfg_write) begin
            unique case (csr_paddr[3:2])
               REG_DEGREE:     degree_ff   <= csr_pwdata[4:0];
               REG_RELAX_REAL: relax_re_ff <= csr_pwdata;
               REG_RELAX_IMAG: relax_im_ff <= csr_pwdata;
               default:        epsilon_ff  <= csr_pwdata[30:0];
            endcase
         end
         // result register and stored point
         if (req_fire && req_type == req_type_LOAD) begin
            old_re_ff <= req_start_real;
            old_im_ff <= req_start_imag;
         end else if (fin_go && !conv_ff) begin
            old_re_ff <= nw_re_ff;
            old_im_ff <= nw_im_ff;
         end
         if ((req_fire && req_type == req_type_LOAD) || fin_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= opnd(issue.opa, old_re_ff, old_im_ff, p1_re_ff, p1_im_ff, p0_re_ff,
                      p0_im_ff, f2_re_ff, f2_im_ff, fx_re_ff, fx_im_ff, ca_re_ff, ca_im_ff,
                      cb_re_ff, cb_im_ff, relax_re_ff, relax_im_ff, s_re_ff, s_im_ff,
                      nw_re_ff, nw_im_ff, k1_ff, k2_ff) *
                 opnd(issue.opb, old_re_ff, old_im_ff, p1_re_ff, p1_im_ff, p0_re_ff,
                      p0_im_ff, f2_re_ff, f2_im_ff, fx_re_ff, fx_im_ff, ca_re_ff, ca_im_ff,
                      cb_re_ff, cb_im_ff, relax_re_ff, relax_im_ff, s_re_ff, s_im_ff,
                      nw_re_ff, nw_im_ff, k1_ff, k2_ff);
      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;

      if (req_fire && req_type == req_type_LOAD) begin
         rsp_re_ff   <= req_start_real;
         rsp_im_ff   <= req_start_imag;
         rsp_conv_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_re_ff   <= nw_re_ff;
         rsp_im_ff   <= nw_im_ff;
         rsp_conv_ff <= conv_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            p1_re_ff <= old_re_ff;
            p1_im_ff <= old_im_ff;
            k1_ff    <= {1'b0, a_clamp} + 6'd1;
            k2_ff    <= 10'(({1'b0, a_clamp} + 6'd1) * a_clamp);
            pcnt_ff  <= a_clamp - 5'd2;
            pass_ff  <= 1'b0;
         end
         ST_POW: if (wb) begin
            p1_re_ff <= sat_word(acc0_in);
            p1_im_ff <= sat_word(acc1_in);
            pcnt_ff  <= pcnt_ff - 5'd1;
         end
         ST_PA: if (wb) begin
            p0_re_ff <= sat_word(acc0_in);
            p0_im_ff <= sat_word(acc1_in);
         end
         ST_PA2: if (wb) begin
            fx_re_ff <= sat_word(ext(sat_word(acc0_in)) - ext(old_re_ff));
            fx_im_ff <= sat_word(ext(sat_word(acc1_in)) - ext(old_im_ff));
         end
         ST_F2: if (wb) begin
            f2_re_ff <= sat_word(acc0_in);
            f2_im_ff <= sat_word(acc1_in);
         end
         ST_F1: if (wb) begin
            f1_re_ff <= sat_word(acc0_in - (acc_type'(1) <<< FRAC_BITS));
            f1_im_ff <= sat_word(acc1_in);
         end
         ST_NUM: if (wb) begin
            ca_re_ff <= sat_word(acc0_in);
            ca_im_ff <= sat_word(acc1_in);
            cb_re_ff <= sat_word(ext(f1_re_ff) <<< 1);
            cb_im_ff <= sat_word(ext(f1_im_ff) <<< 1);
         end
         ST_DIVM: if (wb) begin
            m_ff   <= acc0_in[M_BITS-1:0];
            pre_ff <= acc1_in;
         end
         ST_DIVP: if (wb) pim_ff <= acc0_in;
         ST_DIVRE, ST_DIVIM: begin
            // restoring division, one quotient bit a cycle
            if (dcnt_ff == 5'd0) begin
               rem_ff <= {1'b0, {PRE_SHIFT{1'b0}}, div_u[M_BITS-1:PRE_SHIFT]};
               nb_ff  <= {div_u[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
               qb_ff  <= '0;
            end else begin
               rem_ff <= div_bit ? div_trial : {rem_ff[M_BITS-1:0], nb_ff[QB_BITS-1]};
               nb_ff  <= {nb_ff[QB_BITS-2:0], 1'b0};
               qb_ff  <= div_q;
            end
            if (div_done) begin
               if (state_ff == ST_DIVRE) s_re_ff <= div_res;
               else s_im_ff <= div_res;
            end
         end
         ST_N2: begin
            cb_re_ff <= sat_word(ext(f1_re_ff) - ext(s_re_ff));
            cb_im_ff <= sat_word(ext(f1_im_ff) - ext(s_im_ff));
            ca_re_ff <= fx_re_ff;
            ca_im_ff <= fx_im_ff;
            pass_ff  <= 1'b1;
         end
         ST_RL: if (wb) begin
            nw_re_ff <= sat_word(ext(old_re_ff) - ext(sat_word(acc0_in)));
            nw_im_ff <= sat_word(ext(old_im_ff) - ext(sat_word(acc1_in)));
         end
         ST_NRM: if (wb) begin
            conv_ff <= ((acc0_in[ACC_BITS-1] ? -acc0_in : acc0_in) <
                        acc_type'({1'b0, epsilon_ff}));
         end
         default: ;
      endcase
   end

   // configuration read back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEGREE:     csr_prdata = {27'd0, degree_ff};
         REG_RELAX_REAL: csr_prdata = relax_re_ff;
         REG_RELAX_IMAG: csr_prdata = relax_im_ff;
         default:        csr_prdata = {1'b0, epsilon_ff};
      endcase
   end

   assign csr_pready    = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_real  = rsp_re_ff;
   assign rsp_new_imag  = rsp_im_ff;
   assign rsp_converged = rsp_conv_ff;

   // checks
   a_fin_result: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> rsp_valid_ff)
      else $error("finished step did not register a result");
   a_conv_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_go && conv_ff) |=> ($stable(old_re_ff) && $stable(old_im_ff)))
      else $error("stored point changed on a converged step");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIVRE || state_ff == ST_DIVIM) && dcnt_ff != 5'd0)
      |-> (rem_ff < {1'b0, m_ff}))
      else $error("divider remainder not below divisor");
   a_pow_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POW) |-> (pcnt_ff != 5'd0))
      else $error("power loop entered with zero count");
endmodule
